// File: rtl/dtsp_pkg.sv
// ============================================================================
// dtsp_pkg
// Shared types, constants and lookup tables of the DTS core sync hunter and
// frame header parser.
// ============================================================================
package dtsp_pkg;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_HEADER,
    PH_SKIP
  } dtsp_phase_t;

  localparam logic [31:0] SYNC_WORD        = 32'h7FFE_8001;
  localparam logic [15:0] SEARCH_RANGE_RST = 16'd16384;
  // Header bytes after the sync word; the count runs 0..HDR_LAST.
  localparam logic [2:0]  HDR_LAST         = 3'd6;
  // Frame size fields at or above this leave bytes to skip (sync plus
  // header bytes is 11, frame size is field plus one).
  localparam logic [13:0] SKIP_MIN_FIELD   = 14'd11;
  localparam logic [13:0] SKIP_FIELD_OFS   = 14'd10;
  localparam logic [2:0]  WIN_LAST_FILL    = 3'd3;

  typedef struct packed {
    logic        status;
    logic [14:0] frame_size;
    logic [3:0]  channel_count;
    logic        lfe_present;
    logic [15:0] sample_rate_hz;
    logic [21:0] bitrate_bps;
    logic [12:0] samples_per_frame;
    logic [15:0] bytes_skipped;
  } dtsp_result_t;

  function automatic logic [3:0] chan_lookup(input logic [5:0] amode);
    logic [3:0] ch;
    unique case (amode)
      6'd0:                               ch = 4'd1;
      6'd1, 6'd2, 6'd3, 6'd4:             ch = 4'd2;
      6'd5, 6'd6:                         ch = 4'd3;
      6'd7, 6'd8:                         ch = 4'd4;
      6'd9:                               ch = 4'd5;
      6'd10, 6'd11, 6'd12:                ch = 4'd6;
      6'd13:                              ch = 4'd7;
      6'd14, 6'd15:                       ch = 4'd8;
      default:                            ch = 4'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [3:0] code);
    logic [15:0] r;
    unique case (code)
      4'd1:    r = 16'd8000;
      4'd2:    r = 16'd16000;
      4'd3:    r = 16'd32000;
      4'd6:    r = 16'd11025;
      4'd7:    r = 16'd22050;
      4'd8:    r = 16'd44100;
      4'd11:   r = 16'd12000;
      4'd12:   r = 16'd24000;
      4'd13:   r = 16'd48000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [21:0] bps_lookup(input logic [4:0] code);
    logic [21:0] r;
    unique case (code)
      5'd0:    r = 22'd32000;
      5'd1:    r = 22'd56000;
      5'd2:    r = 22'd64000;
      5'd3:    r = 22'd96000;
      5'd4:    r = 22'd112000;
      5'd5:    r = 22'd128000;
      5'd6:    r = 22'd192000;
      5'd7:    r = 22'd224000;
      5'd8:    r = 22'd256000;
      5'd9:    r = 22'd320000;
      5'd10:   r = 22'd384000;
      5'd11:   r = 22'd448000;
      5'd12:   r = 22'd512000;
      5'd13:   r = 22'd576000;
      5'd14:   r = 22'd640000;
      5'd15:   r = 22'd754500;
      5'd16:   r = 22'd960000;
      5'd17:   r = 22'd1024000;
      5'd18:   r = 22'd1152000;
      5'd19:   r = 22'd1280000;
      5'd20:   r = 22'd1344000;
      5'd21:   r = 22'd1408000;
      5'd22:   r = 22'd1411200;
      5'd23:   r = 22'd1472000;
      5'd24:   r = 22'd1509750;
      5'd25:   r = 22'd1920000;
      5'd26:   r = 22'd2048000;
      5'd27:   r = 22'd3072000;
      5'd28:   r = 22'd3840000;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/dtsp_ifs.sv
// ============================================================================
// dtsp channel interfaces
// Valid/ready channels for stream bytes, parse results and the search range
// register write.
// ============================================================================
interface dtsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface dtsp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [14:0] frame_size;
  logic [3:0]  channel_count;
  logic        lfe_present;
  logic [15:0] sample_rate_hz;
  logic [21:0] bitrate_bps;
  logic [12:0] samples_per_frame;
  logic [15:0] bytes_skipped;

  modport source (output valid, output status, output frame_size,
                  output channel_count, output lfe_present, output sample_rate_hz,
                  output bitrate_bps, output samples_per_frame,
                  output bytes_skipped, input ready);
  modport sink   (input valid, input status, input frame_size,
                  input channel_count, input lfe_present, input sample_rate_hz,
                  input bitrate_bps, input samples_per_frame,
                  input bytes_skipped, output ready);
endinterface

interface dtsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] search_range;

  modport source (output valid, output search_range, input ready);
  modport sink   (input valid, input search_range, output ready);
endinterface

// File: rtl/dtsp_hdr_decode.sv
// ============================================================================
// dtsp_hdr_decode
// Splits the seven collected header bytes into fields and maps the coded
// ones through the lookup tables.
// ============================================================================
module dtsp_hdr_decode
  import dtsp_pkg::*;
(
  input  logic [55:0]  hdr_word,
  input  logic [15:0]  skipped,
  output dtsp_result_t res,
  output logic         skip_go,
  output logic [13:0]  skip_left
);

  logic [6:0]  nblk;
  logic [13:0] fsize_field;
  logic [5:0]  amode;
  logic [1:0]  lfe_code;
  logic        lfe;
  logic [7:0]  nblk_inc;

  assign nblk        = hdr_word[48:42];
  assign fsize_field = hdr_word[41:28];
  assign amode       = hdr_word[27:22];
  assign lfe_code    = hdr_word[2:1];
  assign lfe         = (lfe_code == 2'd1) || (lfe_code == 2'd2);
  assign nblk_inc    = {1'b0, nblk} + 8'd1;

  always_comb begin
    res.status            = 1'b0;
    res.frame_size        = {1'b0, fsize_field} + 15'd1;
    res.channel_count     = chan_lookup(amode) + {3'b000, lfe};
    res.lfe_present       = lfe;
    res.sample_rate_hz    = rate_lookup(hdr_word[21:18]);
    res.bitrate_bps       = bps_lookup(hdr_word[17:13]);
    res.samples_per_frame = {nblk_inc, 5'b00000};
    res.bytes_skipped     = skipped;
  end

  // Bytes left in the frame after the sync word and the header bytes.
  assign skip_go   = fsize_field >= SKIP_MIN_FIELD;
  assign skip_left = fsize_field - SKIP_FIELD_OFS;

endmodule

// File: rtl/dtsp_out_buf.sv
// ============================================================================
// dtsp_out_buf
// Two-entry output buffer: an output register plus a skid entry, so the
// parser keeps taking bytes while a result waits downstream.
// ============================================================================
module dtsp_out_buf
  import dtsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  dtsp_result_t push_data,
  output logic         space_ok,
  output logic         out_valid,
  input  logic         out_ready,
  output dtsp_result_t out_data
);

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  dtsp_result_t out_data_r, out_data_nxt;
  dtsp_result_t skid_data_r, skid_data_nxt;
  logic         pop;

  assign pop       = out_valid_r & out_ready;
  assign space_ok  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // No push can arrive while the skid entry is held.
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// File: rtl/dts_core_sync_and_header_parser.sv
// ============================================================================
// dts_core_sync_and_header_parser
// Hunts for the DTS core sync word in a byte stream, parses the frame header
// and skips the rest of the frame.
// ============================================================================
// One stream byte is taken per clock while input ready is high, each going
// through the same step on the sync window, header shift register and skip
// counter. A result is pushed into the output buffer with the seventh header
// byte, or with the byte that exceeds the search range (status 1, all other
// fields 0). The output side holds two words, so input ready drops only when
// two results wait downstream. The search range register resets to 16384 and
// is written through the cfg port; the user writes it only while the block is
// idle, which the block itself does not enforce. There is no clearing pass
// after reset. A restart word drops all parse state, searching from its own byte.
module dts_core_sync_and_header_parser
  import dtsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dtsp_in_if.sink     in_word,
  dtsp_out_if.source  out_word,
  dtsp_cfg_if.sink    cfg_word
);

  logic [15:0]  search_range_r;
  dtsp_phase_t  phase_r, phase_nxt, phase_eff;
  logic [31:0]  win_r, win_nxt, win_eff;
  logic [2:0]   fill_r, fill_nxt, fill_eff;
  logic [15:0]  scnt_r, scnt_nxt, scnt_eff;
  logic [2:0]   hcnt_r, hcnt_nxt;
  logic [47:0]  hdr_r, hdr_nxt;
  logic [13:0]  left_r, left_nxt;
  logic [15:0]  fskip_r, fskip_nxt;

  logic         in_acc;
  logic         space_ok;
  logic [7:0]   b;
  logic [31:0]  win_shift;
  logic         searching;
  logic         win_full;
  logic         lost;
  logic         sync_hit;
  logic         hdr_done;
  logic [13:0]  left_dec;
  logic         res_push;
  dtsp_result_t res, dec_res, buf_data;
  logic         skip_go;
  logic [13:0]  skip_left;

  assign in_word.ready  = space_ok;
  assign in_acc         = in_word.valid & space_ok;
  assign b              = in_word.data_byte;
  assign cfg_word.ready = 1'b1;

  // Restart acts before this byte is processed.
  assign phase_eff = in_word.restart ? PH_SEARCH : phase_r;
  assign win_eff   = in_word.restart ? 32'd0 : win_r;
  assign fill_eff  = in_word.restart ? 3'd0 : fill_r;
  assign scnt_eff  = in_word.restart ? 16'd0 : scnt_r;

  assign win_shift = {win_eff[23:0], b};
  assign searching = (phase_eff != PH_HEADER) && (phase_eff != PH_SKIP);
  assign win_full  = fill_eff[2];
  assign lost      = searching && win_full && (scnt_eff >= search_range_r);
  assign sync_hit  = searching && !lost && (win_full || fill_eff == WIN_LAST_FILL)
                     && (win_shift == SYNC_WORD);
  assign hdr_done  = (phase_eff == PH_HEADER) && (hcnt_r == HDR_LAST);
  assign left_dec  = (left_r == 14'd0) ? 14'd0 : left_r - 14'd1;

  dtsp_hdr_decode u_decode (
    .hdr_word  ({hdr_r, b}),
    .skipped   (fskip_r),
    .res       (dec_res),
    .skip_go   (skip_go),
    .skip_left (skip_left)
  );

  always_comb begin
    unique case (phase_eff)
      PH_HEADER: begin
        if (hdr_done) begin
          phase_nxt = skip_go ? PH_SKIP : PH_SEARCH;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_SKIP: begin
        phase_nxt = (left_dec == 14'd0) ? PH_SEARCH : PH_SKIP;
      end
      default: begin
        phase_nxt = sync_hit ? PH_HEADER : PH_SEARCH;
      end
    endcase
  end

  always_comb begin
    win_nxt   = win_eff;
    fill_nxt  = fill_eff;
    scnt_nxt  = scnt_eff;
    hcnt_nxt  = hcnt_r;
    hdr_nxt   = hdr_r;
    left_nxt  = left_r;
    fskip_nxt = fskip_r;
    res_push  = 1'b0;
    res       = dec_res;
    unique case (phase_eff)
      PH_HEADER: begin
        hdr_nxt = {hdr_r[39:0], b};
        if (hdr_done) begin
          res_push = 1'b1;
          hcnt_nxt = 3'd0;
          if (skip_go) begin
            left_nxt = skip_left;
          end else begin
            left_nxt = 14'd0;
            win_nxt  = 32'd0;
            fill_nxt = 3'd0;
            scnt_nxt = 16'd0;
          end
        end else begin
          hcnt_nxt = hcnt_r + 3'd1;
        end
      end
      PH_SKIP: begin
        left_nxt = left_dec;
        if (left_dec == 14'd0) begin
          win_nxt  = 32'd0;
          fill_nxt = 3'd0;
          scnt_nxt = 16'd0;
        end
      end
      default: begin
        win_nxt = win_shift;
        if (lost) begin
          scnt_nxt = 16'd0;
          res_push = 1'b1;
          res      = '0;
          res.status = 1'b1;
        end else begin
          if (win_full) begin
            scnt_nxt = scnt_eff + 16'd1;
          end else begin
            fill_nxt = fill_eff + 3'd1;
          end
          if (sync_hit) begin
            fskip_nxt = scnt_nxt;
            hcnt_nxt  = 3'd0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_range_r <= SEARCH_RANGE_RST;
    end else if (cfg_word.valid) begin
      search_range_r <= cfg_word.search_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      win_r   <= 32'd0;
      fill_r  <= 3'd0;
      scnt_r  <= 16'd0;
      hcnt_r  <= 3'd0;
      left_r  <= 14'd0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      scnt_r  <= scnt_nxt;
      hcnt_r  <= hcnt_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hdr_r   <= hdr_nxt;
      fskip_r <= fskip_nxt;
    end
  end

  dtsp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc & res_push),
    .push_data (res),
    .space_ok  (space_ok),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .out_data  (buf_data)
  );

  assign out_word.status            = buf_data.status;
  assign out_word.frame_size        = buf_data.frame_size;
  assign out_word.channel_count     = buf_data.channel_count;
  assign out_word.lfe_present       = buf_data.lfe_present;
  assign out_word.sample_rate_hz    = buf_data.sample_rate_hz;
  assign out_word.bitrate_bps       = buf_data.bitrate_bps;
  assign out_word.samples_per_frame = buf_data.samples_per_frame;
  assign out_word.bytes_skipped     = buf_data.bytes_skipped;

endmodule
